// ----- sv/assert_macros.svh -----
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, expr, msg)
`endif

`endif

// ----- sv/skst_pkg.sv -----
`timescale 1ns / 1ps
package skst_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int KEY_W = 64;
   localparam int COUNT_W = 11;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_QUERY  = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]       mode;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic               found;
      logic               dropped;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PUT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic search_upd;
      logic shift_rd;
      logic shift_wr;
      logic put;
   } ctrl_type;

   typedef struct packed {
      logic full;
      logic search_go;
      logic shift_go;
      logic is_insert;
   } status_type;

endpackage

// ----- sv/skst_key_ram.sv -----
`timescale 1ns / 1ps
module skst_key_ram #(
   parameter int TABLE_DEPTH = skst_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           we,
   input  logic [$clog2(TABLE_DEPTH)-1:0] waddr,
   input  logic [skst_pkg::KEY_W-1:0]     wdata,
   input  logic [$clog2(TABLE_DEPTH)-1:0] raddr,
   output logic [skst_pkg::KEY_W-1:0]     rdata
);
   import skst_pkg::*;

   logic [KEY_W-1:0] mem [TABLE_DEPTH];
   logic [KEY_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/skst_fsm.sv -----
`timescale 1ns / 1ps
module skst_fsm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_mode,
   input  skst_pkg::status_type status,
   output skst_pkg::ctrl_type   ctrl,
   output logic                 busy,
   output logic                 rsp_strobe
);
   import skst_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_mode)
                  MODE_QUERY:  state_in = ST_SEARCH;
                  MODE_INSERT: state_in = status.full ? ST_DONE : ST_SEARCH;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_SEARCH: begin
            if (status.search_go) begin
               state_in = ST_CMP;
            end else if (status.is_insert) begin
               state_in = ST_SHIFT_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CMP:      state_in = ST_SEARCH;
         ST_SHIFT_RD: state_in = status.shift_go ? ST_SHIFT_WR : ST_PUT;
         ST_SHIFT_WR: state_in = ST_SHIFT_RD;
         ST_PUT:      state_in = ST_DONE;
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl            = '0;
      ctrl.capture    = (state_ff == ST_IDLE) && start;
      ctrl.search_upd = (state_ff == ST_CMP);
      ctrl.shift_rd   = (state_ff == ST_SHIFT_RD) && status.shift_go;
      ctrl.shift_wr   = (state_ff == ST_SHIFT_WR);
      ctrl.put        = (state_ff == ST_PUT);
      busy            = (state_ff != ST_IDLE);
      rsp_strobe      = (state_ff == ST_DONE);
   end

endmodule

// ----- sv/skst_datapath.sv -----
`timescale 1ns / 1ps
module skst_datapath #(
   parameter int TABLE_DEPTH = skst_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  skst_pkg::req_type              req_item,
   input  skst_pkg::ctrl_type             ctrl,
   input  logic [skst_pkg::KEY_W-1:0]     rd_data,
   output logic                           we,
   output logic [$clog2(TABLE_DEPTH)-1:0] waddr,
   output logic [skst_pkg::KEY_W-1:0]     wdata,
   output logic [$clog2(TABLE_DEPTH)-1:0] raddr,
   output skst_pkg::status_type           status,
   output skst_pkg::rsp_type              rsp_item
);
   import skst_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [KEY_W-1:0] key_ff, key_in;
   logic             is_insert_ff, is_insert_in;
   logic [CW-1:0]    lo_ff, lo_in;
   logic [CW-1:0]    hi_ff, hi_in;
   logic [CW-1:0]    ptr_ff, ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             found_ff, found_in;
   logic             dropped_ff, dropped_in;

   logic [CW-1:0]    mid;
   logic [CW-1:0]    ptr_m1;
   logic             full;
   logic             key_gt, key_lt, key_eq, go_right;

   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign ptr_m1 = ptr_ff - CW'(1);
   assign full   = (count_ff == CW'(TABLE_DEPTH));

   // shared comparator: stored entry against search key
   assign key_gt   = (rd_data > key_ff);
   assign key_lt   = (rd_data < key_ff);
   assign key_eq   = (rd_data == key_ff);
   assign go_right = is_insert_ff ? !key_gt : key_lt;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      is_insert_ff <= is_insert_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      ptr_ff       <= ptr_in;
      found_ff     <= found_in;
      dropped_ff   <= dropped_in;
   end

   always_comb begin
      key_in       = key_ff;
      is_insert_in = is_insert_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      ptr_in       = ptr_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      dropped_in   = dropped_ff;
      if (ctrl.capture) begin
         key_in       = req_item.key;
         is_insert_in = (req_item.mode == MODE_INSERT);
         lo_in        = '0;
         hi_in        = count_ff;
         ptr_in       = count_ff;
         found_in     = 1'b0;
         dropped_in   = (req_item.mode == MODE_INSERT) && full;
         if (req_item.mode == MODE_CLEAR) begin
            count_in = '0;
         end
      end
      if (ctrl.search_upd) begin
         if (go_right) begin
            lo_in = mid + CW'(1);
         end else begin
            hi_in = mid;
         end
         if (!is_insert_ff && key_eq) begin
            found_in = 1'b1;
         end
      end
      if (ctrl.shift_wr) begin
         ptr_in = ptr_m1;
      end
      if (ctrl.put) begin
         count_in = count_ff + CW'(1);
      end
   end

   assign raddr = ctrl.shift_rd ? ptr_m1[AW-1:0] : mid[AW-1:0];
   assign we    = ctrl.shift_wr || ctrl.put;
   assign waddr = ctrl.shift_wr ? ptr_ff[AW-1:0] : lo_ff[AW-1:0];
   assign wdata = ctrl.shift_wr ? rd_data : key_ff;

   always_comb begin
      status           = '0;
      status.full      = full;
      status.search_go = (lo_ff < hi_ff);
      status.shift_go  = (ptr_ff > lo_ff);
      status.is_insert = is_insert_ff;
   end

   always_comb begin
      rsp_item             = '0;
      rsp_item.found       = found_ff;
      rsp_item.dropped     = dropped_ff;
      rsp_item.entry_count = COUNT_W'(count_ff);
   end

endmodule

// ----- sv/sorted_key_set_lookup_core.sv -----
`timescale 1ns / 1ps
// Sorted key set with binary-search lookup.
// An item (mode, key) is taken when start is high and busy is low. Modes:
// insert a key (duplicates kept, placed after equal keys), query a key,
// clear the table. Every item gives one result on rsp_item, marked by
// rsp_strobe for one cycle; the receiver cannot stall, so results are
// never held back.
// With n keys held, a query makes at most floor(log2(n)) + 1 probes.
// Clear, an unused mode and an insert into a full table go straight to the
// result; an insert searches as a query does, then moves each larger key
// up one place and writes the new key into the gap.
// The block takes one item at a time; busy drops the cycle after the
// strobe. Throughput is set by the single key RAM: each probe is a read
// then a compare, and each moved key is a read then a write.
// Reset empties the table at once; no clearing pass is run, as only held
// entries are ever read.
module sorted_key_set_lookup_core #(
   parameter int TABLE_DEPTH = skst_pkg::TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  skst_pkg::req_type req_item,
   output logic              busy,
   output logic              rsp_strobe,
   output skst_pkg::rsp_type rsp_item
);
   import skst_pkg::*;

   `include "assert_macros.svh"

   localparam int AW = $clog2(TABLE_DEPTH);

   ctrl_type         ctrl;
   status_type       status;
   logic             we;
   logic [AW-1:0]    waddr;
   logic [AW-1:0]    raddr;
   logic [KEY_W-1:0] wdata;
   logic [KEY_W-1:0] rd_data;

   skst_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_mode   (req_item.mode),
      .status     (status),
      .ctrl       (ctrl),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   skst_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .ctrl     (ctrl),
      .rd_data  (rd_data),
      .we       (we),
      .waddr    (waddr),
      .wdata    (wdata),
      .raddr    (raddr),
      .status   (status),
      .rsp_item (rsp_item)
   );

   skst_key_ram #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_key_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rd_data)
   );

   `ASSERT_PROP(a_strobe_single, clock, reset, rsp_strobe |=> !rsp_strobe, "strobe repeated")
   `ASSERT_PROP(a_accept_busy, clock, reset, (start && !busy) |=> busy, "busy not raised")
   `ASSERT_PROP(a_drop_full, clock, reset, (rsp_strobe && rsp_item.dropped) |-> (rsp_item.entry_count == COUNT_W'(TABLE_DEPTH)), "drop with table not full")
   `ASSERT_NEVER(a_found_dropped, clock, reset, rsp_strobe && rsp_item.found && rsp_item.dropped, "found and dropped together")

endmodule

// ----- bench/sorted_key_set_monitor.sv -----
`timescale 1ns / 1ps
module sorted_key_set_monitor #(
   parameter int TABLE_DEPTH = skst_pkg::TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  skst_pkg::req_type req_item,
   input  logic              rsp_strobe,
   input  skst_pkg::rsp_type rsp_item,
   output int                mismatch_count,
   output int                outstanding_count
);
   import skst_pkg::*;

   logic [KEY_W-1:0] held_keys[$];
   rsp_type          expected_rsps[$];
   int               fails = 0;

   function automatic rsp_type predict_lookup(input req_type it);
      rsp_type r;
      int      pos;
      r = '0;
      case (it.mode)
         MODE_INSERT: begin
            if (held_keys.size() >= TABLE_DEPTH) begin
               r.dropped = 1'b1;
            end else begin
               // new key lands after any equal keys
               pos = held_keys.size();
               while (pos > 0 && held_keys[pos-1] > it.key) pos--;
               held_keys.insert(pos, it.key);
            end
         end
         MODE_QUERY: begin
            foreach (held_keys[i]) if (held_keys[i] == it.key) r.found = 1'b1;
         end
         MODE_CLEAR: begin
            held_keys.delete();
         end
         default: ;
      endcase
      r.entry_count = COUNT_W'(held_keys.size());
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         held_keys.delete();
         expected_rsps.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               $error("result with no item outstanding: found %0d dropped %0d count %0d",
                      rsp_item.found, rsp_item.dropped, rsp_item.entry_count);
               fails++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_item.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_item.found);
                  fails++;
               end
               if (rsp_item.dropped !== want.dropped) begin
                  $error("dropped: expected %0d, actual %0d", want.dropped, rsp_item.dropped);
                  fails++;
               end
               if (rsp_item.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, actual %0d",
                         want.entry_count, rsp_item.entry_count);
                  fails++;
               end
            end
         end
         if (start && !busy) expected_rsps.push_back(predict_lookup(req_item));
      end
      mismatch_count    <= fails;
      outstanding_count <= expected_rsps.size();
   end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
   import skst_pkg::*;

   localparam int               TABLE_DEPTH  = TABLE_DEPTH_DEF;
   localparam int               RANDOM_ITEMS = 895;
   localparam logic [1:0]       MODE_UNUSED  = 2'd3;
   localparam logic [KEY_W-1:0] KEY_MAX      = '1;

   typedef enum int {KEYS_WIDE, KEYS_LOW, KEYS_HIGH, KEYS_ONEHOT} key_style_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;
   int      mismatch_count;
   int      outstanding_count;
   bit      no_idle = 1'b0;

   logic [KEY_W-1:0] session_keys[$];

   always #5 clock = ~clock;

   sorted_key_set_lookup_core #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   sorted_key_set_monitor #(.TABLE_DEPTH(TABLE_DEPTH)) monitor (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_item          (req_item),
      .rsp_strobe        (rsp_strobe),
      .rsp_item          (rsp_item),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count)
   );

   task automatic send_item(input logic [1:0] m, input logic [KEY_W-1:0] k);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= '{mode: m, key: k};
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [KEY_W-1:0] draw_key(input key_style_type style);
      logic [KEY_W-1:0] bit_mask;
      bit_mask = KEY_W'(1) << $urandom_range(0, KEY_W-1);
      case (style)
         KEYS_WIDE:   return {$urandom, $urandom};
         KEYS_LOW:    return KEY_W'($urandom_range(0, 15));
         KEYS_HIGH:   return KEY_MAX - KEY_W'($urandom_range(0, 15));
         default:     return $urandom_range(0, 1) ? ~bit_mask : bit_mask;
      endcase
   endfunction

   initial begin : stimulus
      logic [KEY_W-1:0] k;
      key_style_type    style;
      int               target;
      int               random_sent;
      int unsigned      pick;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty table, extremes, duplicates, clear, unused mode
      send_item(MODE_QUERY, '0);
      send_item(MODE_QUERY, KEY_MAX);
      send_item(MODE_INSERT, KEY_MAX);
      send_item(MODE_INSERT, '0);
      send_item(MODE_INSERT, '0);
      send_item(MODE_INSERT, 64'h8000_0000_0000_0000);
      send_item(MODE_INSERT, 64'h5555_5555_5555_5555);
      send_item(MODE_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
      send_item(MODE_QUERY, '0);
      send_item(MODE_QUERY, KEY_MAX);
      send_item(MODE_QUERY, 64'h8000_0000_0000_0000);
      send_item(MODE_QUERY, 64'd1);
      send_item(MODE_QUERY, KEY_MAX - 1);
      send_item(MODE_QUERY, 64'h7FFF_FFFF_FFFF_FFFF);
      send_item(MODE_UNUSED, {$urandom, $urandom});
      send_item(MODE_CLEAR, KEY_MAX);
      send_item(MODE_QUERY, '0);
      send_item(MODE_QUERY, KEY_MAX);
      send_item(MODE_UNUSED, '0);
      send_item(MODE_INSERT, 64'd5);
      send_item(MODE_QUERY, 64'd5);
      send_item(MODE_CLEAR, '0);

      // fill to the top, mostly ascending so shifts stay short
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         no_idle = (i % 128) < 64;
         k = {$urandom, $urandom};
         if ($urandom_range(0, 63) != 0) k = {i[9:0], k[53:0]};
         send_item(MODE_INSERT, k);
      end
      no_idle = 1'b0;
      send_item(MODE_INSERT, '0);
      send_item(MODE_INSERT, KEY_MAX);
      send_item(MODE_INSERT, {$urandom, $urandom});
      send_item(MODE_UNUSED, KEY_MAX);
      send_item(MODE_QUERY, k);
      send_item(MODE_QUERY, {$urandom, $urandom});
      send_item(MODE_QUERY, KEY_MAX);
      send_item(MODE_CLEAR, '0);
      send_item(MODE_QUERY, k);

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         style   = key_style_type'($urandom_range(0, 3));
         target  = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160)
                                               : $urandom_range(0, 40);
         session_keys.delete();
         repeat (target) begin
            pick = $urandom_range(0, 9);
            case (pick)
               0, 1, 2, 3, 4: begin
                  k = draw_key(style);
                  session_keys.push_back(k);
                  send_item(MODE_INSERT, k);
               end
               5, 6: begin
                  if (session_keys.size() != 0)
                     k = session_keys[$urandom_range(0, session_keys.size() - 1)];
                  else
                     k = draw_key(style);
                  send_item(MODE_QUERY, k);
               end
               7: send_item(MODE_QUERY, draw_key(style));
               8: send_item(MODE_QUERY, draw_key(key_style_type'($urandom_range(0, 3))));
               default: begin
                  send_item(MODE_UNUSED, draw_key(KEYS_WIDE));
               end
            endcase
            random_sent++;
         end
         if ($urandom_range(0, 7) != 0) begin
            send_item(MODE_CLEAR, draw_key(KEYS_WIDE));
            random_sent++;
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (outstanding_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && outstanding_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin : watchdog
      #200_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
